[hdl/c6502_pkg.sv]
// c6502_pkg: types, opcode decode and constants for the 6502 subset executor
// no dependencies
package c6502_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PTR_LO = 2'd1,
      PH_PTR_HI = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef enum logic [4:0] {
      K_NONE = 5'd0, K_ORA = 5'd1, K_AND = 5'd2, K_EOR = 5'd3, K_ADC = 5'd4,
      K_SBC = 5'd5, K_CMP = 5'd6, K_CPX = 5'd7, K_CPY = 5'd8, K_LDA = 5'd9,
      K_LDX = 5'd10, K_LDY = 5'd11, K_BIT = 5'd12, K_ASL = 5'd13, K_ROL = 5'd14,
      K_LSR = 5'd15, K_ROR = 5'd16, K_INC = 5'd17, K_DEC = 5'd18, K_STA = 5'd19,
      K_STX = 5'd20, K_STY = 5'd21, K_JMPI = 5'd22, K_PLA = 5'd23, K_PLP = 5'd24
   } kind_type;

   typedef enum logic [2:0] {
      M_NONE = 3'd0, M_ABS = 3'd1, M_ABX = 3'd2, M_ABY = 3'd3,
      M_IZX = 3'd4, M_IZY = 3'd5, M_STK = 3'd6
   } amode_type;

   typedef enum logic [1:0] {
      BUS_NONE = 2'd0,
      BUS_READ = 2'd1,
      BUS_WRITE = 2'd2
   } bus_op_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      amode_type  amode;
   } decode_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] opcode;
      logic [7:0] operand_lo;
      logic [7:0] operand_hi;
      logic [15:0] instr_pc;
      logic [7:0] read_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  bus_op;
      logic [15:0] bus_addr;
      logic [7:0]  bus_wdata;
      logic        done_res;
      logic        fault;
      logic [15:0] next_pc;
      logic [7:0]  reg_a;
      logic [7:0]  reg_x;
      logic [7:0]  reg_y;
      logic [7:0]  reg_sp;
      logic [7:0]  reg_flags;
   } rsp_type;

   localparam logic [7:0] STACK_PAGE = 8'h01;

   function automatic decode_type decode_mem(input logic [7:0] opc);
      decode_type d;
      d = '{valid: 1'b1, kind: K_NONE, amode: M_NONE};
      unique case (opc)
         8'h01: begin d.kind = K_ORA; d.amode = M_IZX; end
         8'h0D: begin d.kind = K_ORA; d.amode = M_ABS; end
         8'h11: begin d.kind = K_ORA; d.amode = M_IZY; end
         8'h1D: begin d.kind = K_ORA; d.amode = M_ABX; end
         8'h0E: begin d.kind = K_ASL; d.amode = M_ABS; end
         8'h1E: begin d.kind = K_ASL; d.amode = M_ABX; end
         8'h21: begin d.kind = K_AND; d.amode = M_IZX; end
         8'h2D: begin d.kind = K_AND; d.amode = M_ABS; end
         8'h31: begin d.kind = K_AND; d.amode = M_IZY; end
         8'h3D: begin d.kind = K_AND; d.amode = M_ABX; end
         8'h2C: begin d.kind = K_BIT; d.amode = M_ABS; end
         8'h2E: begin d.kind = K_ROL; d.amode = M_ABS; end
         8'h3E: begin d.kind = K_ROL; d.amode = M_ABX; end
         8'h41: begin d.kind = K_EOR; d.amode = M_IZX; end
         8'h4D: begin d.kind = K_EOR; d.amode = M_ABS; end
         8'h51: begin d.kind = K_EOR; d.amode = M_IZY; end
         8'h5D: begin d.kind = K_EOR; d.amode = M_ABX; end
         8'h4E: begin d.kind = K_LSR; d.amode = M_ABS; end
         8'h5E: begin d.kind = K_LSR; d.amode = M_ABX; end
         8'h61: begin d.kind = K_ADC; d.amode = M_IZX; end
         8'h6D: begin d.kind = K_ADC; d.amode = M_ABS; end
         8'h71: begin d.kind = K_ADC; d.amode = M_IZY; end
         8'h7D: begin d.kind = K_ADC; d.amode = M_ABX; end
         8'h6E: begin d.kind = K_ROR; d.amode = M_ABS; end
         8'h7E: begin d.kind = K_ROR; d.amode = M_ABX; end
         8'h6C: begin d.kind = K_JMPI; d.amode = M_ABS; end
         8'h81: begin d.kind = K_STA; d.amode = M_IZX; end
         8'h8C: begin d.kind = K_STY; d.amode = M_ABS; end
         8'h8D: begin d.kind = K_STA; d.amode = M_ABS; end
         8'h8E: begin d.kind = K_STX; d.amode = M_ABS; end
         8'h91: begin d.kind = K_STA; d.amode = M_IZY; end
         8'h9D: begin d.kind = K_STA; d.amode = M_ABX; end
         8'hA1: begin d.kind = K_LDA; d.amode = M_IZX; end
         8'hAC: begin d.kind = K_LDY; d.amode = M_ABS; end
         8'hAD: begin d.kind = K_LDA; d.amode = M_ABS; end
         8'hAE: begin d.kind = K_LDX; d.amode = M_ABS; end
         8'hB1: begin d.kind = K_LDA; d.amode = M_IZY; end
         8'hBC: begin d.kind = K_LDY; d.amode = M_ABX; end
         8'hBD: begin d.kind = K_LDA; d.amode = M_ABX; end
         8'hBE: begin d.kind = K_LDX; d.amode = M_ABY; end
         8'hC1: begin d.kind = K_CMP; d.amode = M_IZX; end
         8'hCC: begin d.kind = K_CPY; d.amode = M_ABS; end
         8'hCD: begin d.kind = K_CMP; d.amode = M_ABS; end
         8'hCE: begin d.kind = K_DEC; d.amode = M_ABS; end
         8'hD1: begin d.kind = K_CMP; d.amode = M_IZY; end
         8'hDD: begin d.kind = K_CMP; d.amode = M_ABX; end
         8'hDE: begin d.kind = K_DEC; d.amode = M_ABX; end
         8'hE1: begin d.kind = K_SBC; d.amode = M_IZX; end
         8'hEC: begin d.kind = K_CPX; d.amode = M_ABS; end
         8'hED: begin d.kind = K_SBC; d.amode = M_ABS; end
         8'hEE: begin d.kind = K_INC; d.amode = M_ABS; end
         8'hF1: begin d.kind = K_SBC; d.amode = M_IZY; end
         8'hFD: begin d.kind = K_SBC; d.amode = M_ABX; end
         8'hFE: begin d.kind = K_INC; d.amode = M_ABX; end
         8'h68: begin d.kind = K_PLA; d.amode = M_STK; end
         8'h28: begin d.kind = K_PLP; d.amode = M_STK; end
         default: d.valid = 1'b0;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
      return (p & 8'h7D) | (v & 8'h80) | ((v == 8'h00) ? 8'h02 : 8'h00);
   endfunction

   function automatic logic [7:0] with_c(input logic [7:0] p, input logic c);
      return {p[7:1], c};
   endfunction

endpackage

[hdl/c6502_stream_if.sv]
// c6502_stream_if: valid/ready channel carrying one payload type
// no dependencies; the payload type is a parameter
interface c6502_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/c6502_exec.sv]
// c6502_exec: combinational step of the 6502 subset, next state and result
// depends on c6502_pkg
module c6502_exec (
   input  c6502_pkg::req_type    req,
   input  logic [7:0]            a,
   input  logic [7:0]            x,
   input  logic [7:0]            y,
   input  logic [7:0]            sp,
   input  logic [7:0]            p,
   input  c6502_pkg::phase_type  phase,
   input  logic [7:0]            h_opc,
   input  logic [15:0]           h_addr,
   input  logic [15:0]           h_pc,
   input  logic [7:0]            ptr_lo,
   output logic [7:0]            a_o,
   output logic [7:0]            x_o,
   output logic [7:0]            y_o,
   output logic [7:0]            sp_o,
   output logic [7:0]            p_o,
   output c6502_pkg::phase_type  phase_o,
   output logic [7:0]            h_opc_o,
   output logic [15:0]           h_addr_o,
   output logic [15:0]           h_pc_o,
   output logic [7:0]            ptr_lo_o,
   output c6502_pkg::rsp_type    rsp
);

   c6502_pkg::decode_type dec;
   logic [7:0]  lo;
   logic [15:0] base;
   logic [15:0] pc1;
   logic [15:0] pc2;
   logic [15:0] pc3;
   logic [15:0] addr;
   logic [7:0]  d;
   logic [7:0]  m;
   logic [7:0]  v;
   logic [8:0]  sum;
   logic [8:0]  diff;
   logic [7:0]  cmp_reg;
   logic        cin;

   always_comb begin
      lo = req.operand_lo;
      base = {req.operand_hi, req.operand_lo};
      pc1 = req.instr_pc + 16'd1;
      pc2 = req.instr_pc + 16'd2;
      pc3 = req.instr_pc + 16'd3;
      d = req.read_data;
      cin = p[0];
      dec = c6502_pkg::decode_mem(req.mode ? h_opc : req.opcode);
      m = (dec.kind == c6502_pkg::K_SBC) ? ~d : d;
      sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};
      unique case (dec.kind)
         c6502_pkg::K_CPX: cmp_reg = x;
         c6502_pkg::K_CPY: cmp_reg = y;
         default: cmp_reg = a;
      endcase
      diff = {1'b0, cmp_reg} - {1'b0, d};
      addr = {d, ptr_lo};
      v = 8'd0;

      a_o = a; x_o = x; y_o = y; sp_o = sp; p_o = p;
      phase_o = phase; h_opc_o = h_opc; h_addr_o = h_addr; h_pc_o = h_pc;
      ptr_lo_o = ptr_lo;
      rsp = '0;

      if (!req.mode) begin
         phase_o = c6502_pkg::PH_IDLE;
         h_opc_o = req.opcode;
         rsp.done_res = 1'b1;
         rsp.next_pc = pc1;
         unique case (req.opcode)
            8'h08, 8'h48: begin
               rsp.bus_op = c6502_pkg::BUS_WRITE;
               rsp.bus_addr = {c6502_pkg::STACK_PAGE, sp};
               rsp.bus_wdata = (req.opcode == 8'h08) ? p : a;
               sp_o = sp - 8'd1;
            end
            8'h0A: begin
               a_o = {a[6:0], 1'b0};
               p_o = c6502_pkg::with_nz(c6502_pkg::with_c(p, a[7]), a_o);
            end
            8'h2A: begin
               a_o = {a[6:0], cin};
               p_o = c6502_pkg::with_nz(c6502_pkg::with_c(p, a[7]), a_o);
            end
            8'h4A: begin
               a_o = {1'b0, a[7:1]};
               p_o = c6502_pkg::with_nz(c6502_pkg::with_c(p, a[0]), a_o);
            end
            8'h6A: begin
               a_o = {cin, a[7:1]};
               p_o = c6502_pkg::with_nz(c6502_pkg::with_c(p, a[0]), a_o);
            end
            8'h10: rsp.next_pc = p[7] ? pc2 : pc2 + {{8{lo[7]}}, lo};
            8'h4C: rsp.next_pc = base;
            8'h18: p_o = p & 8'hFE;
            8'h38: p_o = p | 8'h01;
            8'h58: p_o = p & 8'hFB;
            8'h78: p_o = p | 8'h04;
            8'hB8: p_o = p & 8'hBF;
            8'hD8: p_o = p & 8'hF7;
            8'hF8: p_o = p | 8'h08;
            8'h88: begin y_o = y - 8'd1; p_o = c6502_pkg::with_nz(p, y_o); end
            8'hC8: begin y_o = y + 8'd1; p_o = c6502_pkg::with_nz(p, y_o); end
            8'hCA: begin x_o = x - 8'd1; p_o = c6502_pkg::with_nz(p, x_o); end
            8'hE8: begin x_o = x + 8'd1; p_o = c6502_pkg::with_nz(p, x_o); end
            8'h8A: begin a_o = x; p_o = c6502_pkg::with_nz(p, x); end
            8'h98: begin a_o = y; p_o = c6502_pkg::with_nz(p, y); end
            8'hA8: begin y_o = a; p_o = c6502_pkg::with_nz(p, a); end
            8'hAA: begin x_o = a; p_o = c6502_pkg::with_nz(p, a); end
            8'h9A: sp_o = x;
            8'hBA: begin x_o = sp; p_o = c6502_pkg::with_nz(p, sp); end
            8'hA0: begin y_o = lo; p_o = c6502_pkg::with_nz(p, lo); rsp.next_pc = pc2; end
            8'hA2: begin x_o = lo; p_o = c6502_pkg::with_nz(p, lo); rsp.next_pc = pc2; end
            8'hEA: ;
            default: begin
               if (!dec.valid) begin
                  rsp.fault = 1'b1;
                  rsp.next_pc = req.instr_pc;
               end else if (dec.amode == c6502_pkg::M_STK) begin
                  rsp = '0;
                  h_pc_o = pc1;
                  sp_o = sp + 8'd1;
                  h_addr_o = {c6502_pkg::STACK_PAGE, sp_o};
                  rsp.bus_op = c6502_pkg::BUS_READ;
                  rsp.bus_addr = h_addr_o;
                  phase_o = c6502_pkg::PH_DATA;
               end else if (dec.amode == c6502_pkg::M_IZX ||
                            dec.amode == c6502_pkg::M_IZY) begin
                  rsp = '0;
                  h_pc_o = pc2;
                  h_addr_o = {8'd0, (dec.amode == c6502_pkg::M_IZX) ? lo + x : lo};
                  rsp.bus_op = c6502_pkg::BUS_READ;
                  rsp.bus_addr = h_addr_o;
                  phase_o = c6502_pkg::PH_PTR_LO;
               end else begin
                  h_pc_o = pc3;
                  rsp.next_pc = pc3;
                  if (dec.amode == c6502_pkg::M_ABX) base = base + {8'd0, x};
                  else if (dec.amode == c6502_pkg::M_ABY) base = base + {8'd0, y};
                  if (dec.kind == c6502_pkg::K_STA || dec.kind == c6502_pkg::K_STX ||
                      dec.kind == c6502_pkg::K_STY) begin
                     rsp.bus_op = c6502_pkg::BUS_WRITE;
                     rsp.bus_addr = base;
                     rsp.bus_wdata = (dec.kind == c6502_pkg::K_STA) ? a :
                                     (dec.kind == c6502_pkg::K_STX) ? x : y;
                  end else begin
                     rsp = '0;
                     h_addr_o = base;
                     rsp.bus_op = c6502_pkg::BUS_READ;
                     rsp.bus_addr = base;
                     phase_o = (dec.kind == c6502_pkg::K_JMPI) ?
                               c6502_pkg::PH_PTR_LO : c6502_pkg::PH_DATA;
                  end
               end
            end
         endcase
      end else if (phase != c6502_pkg::PH_IDLE) begin
         if (!dec.valid) begin
            phase_o = c6502_pkg::PH_IDLE;
         end else begin
            unique case (phase)
               c6502_pkg::PH_PTR_LO: begin
                  ptr_lo_o = d;
                  h_addr_o = (dec.kind == c6502_pkg::K_JMPI) ? h_addr + 16'd1 :
                             {8'd0, h_addr[7:0] + 8'd1};
                  rsp.bus_op = c6502_pkg::BUS_READ;
                  rsp.bus_addr = h_addr_o;
                  phase_o = c6502_pkg::PH_PTR_HI;
               end
               c6502_pkg::PH_PTR_HI: begin
                  if (dec.amode == c6502_pkg::M_IZY) addr = addr + {8'd0, y};
                  if (dec.kind == c6502_pkg::K_JMPI) begin
                     rsp.done_res = 1'b1;
                     rsp.next_pc = {d, ptr_lo};
                     phase_o = c6502_pkg::PH_IDLE;
                  end else if (dec.kind == c6502_pkg::K_STA) begin
                     rsp.bus_op = c6502_pkg::BUS_WRITE;
                     rsp.bus_addr = addr;
                     rsp.bus_wdata = a;
                     rsp.done_res = 1'b1;
                     rsp.next_pc = h_pc;
                     phase_o = c6502_pkg::PH_IDLE;
                  end else begin
                     h_addr_o = addr;
                     rsp.bus_op = c6502_pkg::BUS_READ;
                     rsp.bus_addr = addr;
                     phase_o = c6502_pkg::PH_DATA;
                  end
               end
               default: begin
                  rsp.done_res = 1'b1;
                  rsp.next_pc = h_pc;
                  phase_o = c6502_pkg::PH_IDLE;
                  unique case (dec.kind)
                     c6502_pkg::K_ORA: begin a_o = a | d; p_o = c6502_pkg::with_nz(p, a_o); end
                     c6502_pkg::K_AND: begin a_o = a & d; p_o = c6502_pkg::with_nz(p, a_o); end
                     c6502_pkg::K_EOR: begin a_o = a ^ d; p_o = c6502_pkg::with_nz(p, a_o); end
                     c6502_pkg::K_ADC, c6502_pkg::K_SBC: begin
                        a_o = sum[7:0];
                        p_o = (p & 8'hBF) |
                              {1'b0, (~(a[7] ^ m[7])) & (a[7] ^ sum[7]), 6'd0};
                        p_o = c6502_pkg::with_nz(c6502_pkg::with_c(p_o, sum[8]), a_o);
                     end
                     c6502_pkg::K_CMP, c6502_pkg::K_CPX, c6502_pkg::K_CPY:
                        p_o = c6502_pkg::with_c(c6502_pkg::with_nz(p, diff[7:0]), !diff[8]);
                     c6502_pkg::K_LDA, c6502_pkg::K_PLA: begin
                        a_o = d; p_o = c6502_pkg::with_nz(p, d);
                     end
                     c6502_pkg::K_LDX: begin x_o = d; p_o = c6502_pkg::with_nz(p, d); end
                     c6502_pkg::K_LDY: begin y_o = d; p_o = c6502_pkg::with_nz(p, d); end
                     c6502_pkg::K_PLP: p_o = d;
                     c6502_pkg::K_BIT:
                        p_o = (p & 8'h3D) | (d & 8'hC0) | (((a & d) == 8'd0) ? 8'h02 : 8'h00);
                     c6502_pkg::K_ASL, c6502_pkg::K_ROL, c6502_pkg::K_LSR,
                     c6502_pkg::K_ROR, c6502_pkg::K_INC, c6502_pkg::K_DEC: begin
                        p_o = p;
                        unique case (dec.kind)
                           c6502_pkg::K_ASL: begin v = {d[6:0], 1'b0}; p_o = c6502_pkg::with_c(p, d[7]); end
                           c6502_pkg::K_ROL: begin v = {d[6:0], cin}; p_o = c6502_pkg::with_c(p, d[7]); end
                           c6502_pkg::K_LSR: begin v = {1'b0, d[7:1]}; p_o = c6502_pkg::with_c(p, d[0]); end
                           c6502_pkg::K_ROR: begin v = {cin, d[7:1]}; p_o = c6502_pkg::with_c(p, d[0]); end
                           c6502_pkg::K_INC: v = d + 8'd1;
                           default: v = d - 8'd1;
                        endcase
                        p_o = c6502_pkg::with_nz(p_o, v);
                        rsp.bus_op = c6502_pkg::BUS_WRITE;
                        rsp.bus_addr = h_addr;
                        rsp.bus_wdata = v;
                     end
                     default: ;
                  endcase
               end
            endcase
         end
      end

      rsp.reg_a = a_o;
      rsp.reg_x = x_o;
      rsp.reg_y = y_o;
      rsp.reg_sp = sp_o;
      rsp.reg_flags = p_o;
   end

endmodule

[hdl/cpu6502_instruction_execute.sv]
// cpu6502_instruction_execute: top level, architectural registers and output register
// depends on c6502_pkg, c6502_stream_if, c6502_exec
//
//   channel  dir  payload
//   req      in   mode, opcode, operand_lo, operand_hi, instr_pc, read_data
//   rsp      out  bus_op, bus_addr, bus_wdata, done_res, fault, next_pc, registers
//
// one request per cycle unless the output register is full and not drained; the result
// of the combinational decode and alu step is captured in the output register on take
// reset clears the phase and all registers but out_ff, output register empty
// a request is taken whenever the output register is empty or being drained
module cpu6502_instruction_execute (
   input logic clock,
   input logic reset,
   c6502_stream_if.sink   req,
   c6502_stream_if.source rsp
);

   logic [7:0]  a_ff, x_ff, y_ff, sp_ff, p_ff, h_opc_ff, ptr_lo_ff;
   logic [7:0]  a_in, x_in, y_in, sp_in, p_in, h_opc_in, ptr_lo_in;
   logic [15:0] h_addr_ff, h_pc_ff, h_addr_in, h_pc_in;
   c6502_pkg::phase_type phase_ff, phase_in;
   c6502_pkg::rsp_type   out_ff, out_in;
   logic                 out_valid_ff;
   logic                 take;

   assign req.ready = !out_valid_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   c6502_exec u_exec (
      .req(req.data), .a(a_ff), .x(x_ff), .y(y_ff), .sp(sp_ff), .p(p_ff),
      .phase(phase_ff), .h_opc(h_opc_ff), .h_addr(h_addr_ff), .h_pc(h_pc_ff),
      .ptr_lo(ptr_lo_ff),
      .a_o(a_in), .x_o(x_in), .y_o(y_in), .sp_o(sp_in), .p_o(p_in),
      .phase_o(phase_in), .h_opc_o(h_opc_in), .h_addr_o(h_addr_in), .h_pc_o(h_pc_in),
      .ptr_lo_o(ptr_lo_in), .rsp(out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; x_ff <= '0; y_ff <= '0; sp_ff <= '0; p_ff <= '0;
         h_opc_ff <= '0; ptr_lo_ff <= '0; h_addr_ff <= '0; h_pc_ff <= '0;
         phase_ff <= c6502_pkg::PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; p_ff <= p_in;
            h_opc_ff <= h_opc_in; ptr_lo_ff <= ptr_lo_in;
            h_addr_ff <= h_addr_in; h_pc_ff <= h_pc_in;
            phase_ff <= phase_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      take && out_in.done_res |=> phase_ff == c6502_pkg::PH_IDLE)
      else $error("completion left a pending phase");
   a_read_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.bus_op == c6502_pkg::BUS_READ |-> !rsp.data.done_res)
      else $error("read request marked done");
   a_fault_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.fault |-> rsp.data.done_res &&
      rsp.data.bus_op == c6502_pkg::BUS_NONE)
      else $error("fault without completion");
   a_regs_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(a_ff) && $stable(p_ff) && $stable(phase_ff))
      else $error("state moved without a request");
`endif

endmodule
